[sv/ccs_pkg.sv]
// Shared types and constants for the ChaCha20 stream cipher block.
// No dependencies; every other file of the block but ccs_if imports this package.
package ccs_pkg;

  typedef logic [31:0] word_t;

  // "expand 32-byte k" as four little-endian words.
  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  // Configuration port layout.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CNT = 3'd6;

  // Rotation applied by the add-xor-rotate unit, one per quarter-round step.
  typedef enum logic [1:0] {
    ROT16,
    ROT12,
    ROT8,
    ROT7
  } rot_t;

  // Everything the block function needs besides the constants.
  typedef struct packed {
    word_t [7:0] key;
    word_t [2:0] nonce;
    word_t       counter;
  } ccs_cfg_t;

  typedef struct packed {
    logic start;
  } ccs_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ccs_sts_t;

endpackage

[sv/ccs_if.sv]
// Item channels of the ChaCha20 stream cipher: input bytes and result bytes.
// Depends on nothing; valid/ready handshake, an item moves when both are high.
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink (input valid, input data_byte, input message_start, output ready);
endinterface

interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

[sv/ccs_arx.sv]
// Shared 32-bit add, xor and rotate unit of the ChaCha20 block function.
// Depends on ccs_pkg for the word and rotation types.
module ccs_arx import ccs_pkg::*; (
  input  word_t x,
  input  word_t y,
  input  word_t z,
  input  rot_t  rot,
  output word_t sum,
  output word_t mix
);

  always_comb begin
    word_t t;
    sum = x + y;
    t   = z ^ sum;
    unique case (rot)
      ROT16: mix = {t[15:0], t[31:16]};
      ROT12: mix = {t[19:0], t[31:20]};
      ROT8:  mix = {t[23:0], t[31:24]};
      ROT7:  mix = {t[24:0], t[31:25]};
    endcase
  end

endmodule

[sv/ccs_core.sv]
// Keystream block generator: a sequencer drives the shared add-xor-rotate unit
// through all rounds and the feed-forward. Depends on ccs_pkg and ccs_arx.
module ccs_core import ccs_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ccs_cfg_t   cfg,
  input  ccs_ctl_t   ctl,
  output ccs_sts_t   sts,
  input  logic [5:0] ks_pos,
  output logic [7:0] ks_byte
);

  localparam int DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FEED
  } core_state_t;

  core_state_t      st_r;
  logic [1:0]       step_r;
  logic [2:0]       qr_r;
  logic [DrW-1:0]   dr_r;
  logic [3:0]       ff_r;
  logic             done_r;

  word_t w_r   [16];
  word_t w_nxt [16];
  word_t arx_x, arx_y, arx_z, arx_sum, arx_mix;
  rot_t  arx_rot;

  function automatic word_t init_word(input ccs_cfg_t c, input logic [3:0] idx);
    word_t r;
    if (idx < 4'd4) begin
      r = SIGMA[idx[1:0]];
    end else if (idx < 4'd12) begin
      r = c.key[3'(idx - 4'd4)];
    end else if (idx == 4'd12) begin
      r = c.counter;
    end else begin
      r = c.nonce[2'(idx - 4'd13)];
    end
    return r;
  endfunction

  // The quarter-round operands always sit in column 0 (words 0, 4, 8, 12);
  // the rows are rotated after each quarter-round to bring the next one there.
  always_comb begin
    arx_x   = w_r[0];
    arx_y   = w_r[4];
    arx_z   = w_r[12];
    arx_rot = ROT16;
    unique case (step_r)
      2'd0: arx_rot = ROT16;
      2'd1: begin
        arx_x   = w_r[8];
        arx_y   = w_r[12];
        arx_z   = w_r[4];
        arx_rot = ROT12;
      end
      2'd2: arx_rot = ROT8;
      2'd3: begin
        arx_x   = w_r[8];
        arx_y   = w_r[12];
        arx_z   = w_r[4];
        arx_rot = ROT7;
      end
    endcase
    if (st_r == C_FEED) begin
      arx_x = w_r[0];
      arx_y = init_word(cfg, ff_r);
    end
  end

  ccs_arx u_arx (
    .x   (arx_x),
    .y   (arx_y),
    .z   (arx_z),
    .rot (arx_rot),
    .sum (arx_sum),
    .mix (arx_mix)
  );

  always_comb begin
    word_t      arx_w [16];
    logic [1:0] sh    [4];
    logic [1:0] col;
    arx_w = w_r;
    col   = '0;
    if (step_r[0] == 1'b0) begin
      arx_w[0]  = arx_sum;
      arx_w[12] = arx_mix;
    end else begin
      arx_w[8] = arx_sum;
      arx_w[4] = arx_mix;
    end
    // Row shifts at the end of a quarter-round. The last column step also
    // moves the diagonals into the columns; the last diagonal step undoes it.
    for (int r = 0; r < 4; r++) begin
      if (qr_r == 3'd3) begin
        sh[r] = 2'(r + 1);
      end else if (qr_r == 3'd7) begin
        sh[r] = 2'(5 - r);
      end else begin
        sh[r] = 2'd1;
      end
    end
    w_nxt = w_r;
    unique case (st_r)
      C_IDLE: begin
        if (ctl.start) begin
          for (int i = 0; i < 16; i++) begin
            w_nxt[i] = init_word(cfg, 4'(i));
          end
        end
      end
      C_ROUND: begin
        if (step_r == 2'd3) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              col = 2'(j) + sh[r];
              w_nxt[4*r+j] = arx_w[{2'(r), col}];
            end
          end
        end else begin
          w_nxt = arx_w;
        end
      end
      C_FEED: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = arx_sum;
      end
      default: w_nxt = w_r;
    endcase
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      step_r <= '0;
      qr_r   <= '0;
      dr_r   <= '0;
      ff_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        C_IDLE: begin
          if (ctl.start) begin
            st_r   <= C_ROUND;
            step_r <= '0;
            qr_r   <= '0;
            dr_r   <= '0;
            ff_r   <= '0;
          end
        end
        C_ROUND: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            qr_r <= qr_r + 3'd1;
            if (qr_r == 3'd7) begin
              dr_r <= dr_r + DrW'(1);
              if (dr_r == DrW'(DOUBLE_ROUNDS - 1)) begin
                st_r <= C_FEED;
              end
            end
          end
        end
        C_FEED: begin
          ff_r <= ff_r + 4'd1;
          if (ff_r == 4'd15) begin
            st_r   <= C_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign sts.busy = (st_r != C_IDLE);
  assign sts.done = done_r;

  always_comb begin
    word_t word;
    word = w_r[ks_pos[5:2]];
    case (ks_pos[1:0])
      2'd0:    ks_byte = word[7:0];
      2'd1:    ks_byte = word[15:8];
      2'd2:    ks_byte = word[23:16];
      default: ks_byte = word[31:24];
    endcase
  end

endmodule

[sv/chacha20_stream_cipher_top.sv]
// Top level of the ChaCha20 stream cipher: configuration registers, byte
// stream control and result register. Depends on ccs_pkg, ccs_if and ccs_core.
//
// Each input item is one byte; the block returns exactly one result item, the
// byte XOR the next ChaCha20 keystream byte (RFC 8439 layout: constants, 256-bit
// key, 32-bit block counter, 96-bit nonce). A byte flagged message_start, or the
// first byte after reset, reloads the block counter from start_counter; after
// every 64 bytes the counter increments, wrapping modulo 2^32. A byte that uses
// the current keystream block can be followed by the next one in the next cycle
// as long as the receiver takes the previous result in that cycle; a result
// that is not taken holds off the next byte. A byte that needs a new block
// waits while a single 32-bit add-xor-rotate unit performs each quarter-round
// as four steps, one per cycle, and then adds the input state back one word per
// cycle. Configuration registers are written through cfg_we, cfg_idx and
// cfg_wdata; the user must write them only while no item is in flight, which
// the block does not enforce. A write takes effect at the next keystream
// block, and a write to an unused index is ignored.
module chacha20_stream_cipher_top import ccs_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ccs_in_if.sink                in_item,
  ccs_out_if.source             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOAD,
    T_GEN
  } top_state_t;

  // Configuration registers.
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_lo_r;
  logic [31:0] nonce_hi_r, start_cnt_r;

  // Stream state.
  top_state_t st_r;
  word_t      blk_cnt_r;
  logic [5:0] pos_r;
  logic       blk_ok_r;
  logic [7:0] data_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;

  ccs_cfg_t   core_cfg;
  ccs_ctl_t   core_ctl;
  ccs_sts_t   core_sts;
  logic [7:0] ks_byte;
  logic       accept;
  logic       restart;
  logic       need_blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_cnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KEY0:      key0_r      <= cfg_wdata;
        CFG_KEY1:      key1_r      <= cfg_wdata;
        CFG_KEY2:      key2_r      <= cfg_wdata;
        CFG_KEY3:      key3_r      <= cfg_wdata;
        CFG_NONCE_LO:  nonce_lo_r  <= cfg_wdata;
        CFG_NONCE_HI:  nonce_hi_r  <= cfg_wdata[31:0];
        CFG_START_CNT: start_cnt_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign core_cfg.key      = {key3_r, key2_r, key1_r, key0_r};
  assign core_cfg.nonce    = {nonce_hi_r, nonce_lo_r};
  assign core_cfg.counter  = blk_cnt_r;
  assign core_ctl.start    = (st_r == T_LOAD);

  ccs_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (core_cfg),
    .ctl     (core_ctl),
    .sts     (core_sts),
    .ks_pos  (pos_r),
    .ks_byte (ks_byte)
  );

  // A new item is taken only when the result register is free or is being
  // emptied in the same cycle, so a finished result never blocks the input
  // longer than one handshake.
  assign in_item.ready = (st_r == T_IDLE) && !core_sts.busy
                         && (!out_valid_r || out_item.ready);
  assign accept   = in_item.valid && in_item.ready;
  assign restart  = in_item.message_start || !blk_ok_r;
  assign need_blk = restart || (pos_r == 6'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      blk_cnt_r   <= '0;
      pos_r       <= '0;
      blk_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        T_IDLE: begin
          if (accept) begin
            if (need_blk) begin
              // The counter is settled here so the core samples it next cycle.
              data_r   <= in_item.data_byte;
              blk_ok_r <= 1'b1;
              st_r     <= T_LOAD;
              if (restart) begin
                blk_cnt_r <= start_cnt_r;
                pos_r     <= '0;
              end else begin
                blk_cnt_r <= blk_cnt_r + 32'd1;
              end
            end else begin
              out_byte_r  <= in_item.data_byte ^ ks_byte;
              out_valid_r <= 1'b1;
              pos_r       <= pos_r + 6'd1;
            end
          end
        end
        T_LOAD: begin
          st_r <= T_GEN;
        end
        T_GEN: begin
          if (core_sts.done) begin
            out_byte_r  <= data_r ^ ks_byte;
            out_valid_r <= 1'b1;
            pos_r       <= pos_r + 6'd1;
            st_r        <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.result_byte = out_byte_r;

endmodule

[sim/tb.sv]
// Self-checking testbench for the ChaCha20 stream cipher top level.
// Depends on ccs_pkg and the ccs_in_if / ccs_out_if channel interfaces; it
// predicts every result byte with its own ChaCha20 keystream generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  // Must match the parameter handed to the block below.
  localparam int DOUBLE_ROUNDS = 10;

  // The limit allows for the worst case of about 1100 items that each start a
  // message and whose results each wait out a long receiver stall, and leaves
  // ample room on top of that.
  localparam int CYCLE_LIMIT = 2_000_000;

  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 130;

  // The index space has room for eight registers; the last one is not used.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Keeps its own copy of the key, nonce and counter settings, regenerates
  // the keystream exactly as the block should, and queues one expected
  // result byte for every input byte that the block accepts.
  class cipher_scoreboard;
    word_t       key_w [8];
    word_t       nonce_w [3];
    word_t       first_count;
    word_t       ks_w [16];
    word_t       work [16];
    word_t       block_count;
    logic [5:0]  pos;
    bit          have_block;
    logic [7:0]  expected_bytes [$];
    int          errors;
    int          blocks_made;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      foreach (nonce_w[i]) nonce_w[i] = '0;
      first_count = '0;
      block_count = '0;
      pos         = '0;
      have_block  = 1'b0;
      errors      = 0;
      blocks_made = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_KEY0: begin
          key_w[0] = val[31:0];
          key_w[1] = val[63:32];
        end
        CFG_KEY1: begin
          key_w[2] = val[31:0];
          key_w[3] = val[63:32];
        end
        CFG_KEY2: begin
          key_w[4] = val[31:0];
          key_w[5] = val[63:32];
        end
        CFG_KEY3: begin
          key_w[6] = val[31:0];
          key_w[7] = val[63:32];
        end
        CFG_NONCE_LO: begin
          nonce_w[0] = val[31:0];
          nonce_w[1] = val[63:32];
        end
        CFG_NONCE_HI:  nonce_w[2]  = val[31:0];
        CFG_START_CNT: first_count = val[31:0];
        default: ;
      endcase
    endfunction

    function word_t rotl(word_t v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      work[a] = work[a] + work[b];
      work[d] = rotl(work[d] ^ work[a], 16);
      work[c] = work[c] + work[d];
      work[b] = rotl(work[b] ^ work[c], 12);
      work[a] = work[a] + work[b];
      work[d] = rotl(work[d] ^ work[a], 8);
      work[c] = work[c] + work[d];
      work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    function void refill_keystream();
      word_t init [16];
      init[0] = 32'h61707865;
      init[1] = 32'h3320646e;
      init[2] = 32'h79622d32;
      init[3] = 32'h6b206574;
      for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
      init[12] = block_count;
      for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
      work = init;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_w[i] = work[i] + init[i];
      blocks_made++;
    endfunction

    function void note_input(logic [7:0] data, logic start);
      word_t w;
      if (start || !have_block) begin
        block_count = first_count;
        pos         = '0;
        refill_keystream();
        have_block  = 1'b1;
      end else if (pos == 6'd0) begin
        block_count = block_count + 32'd1;
        refill_keystream();
      end
      w = ks_w[pos[5:2]];
      expected_bytes.push_back(data ^ w[pos[1:0] * 8 +: 8]);
      pos = pos + 6'd1;
    endfunction

    function void check_result(logic [7:0] actual);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: result_byte expected none, actual %02h", $time, actual);
        return;
      end
      want = expected_bytes.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: result_byte expected %02h, actual %02h", $time, want, actual);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ccs_in_if  in_ch ();
  ccs_out_if out_ch ();

  chacha20_stream_cipher_top #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  cipher_scoreboard sb;

  // Chance, in percent, that the sender idles before an item and that the
  // receiver holds ready low in a given cycle.
  int idle_pct  = 0;
  int stall_pct = 0;

  int cycles        = 0;
  int items_sent    = 0;
  int message_count = 0;
  int setting_count = 0;

  always #4 clk = ~clk;

  // Receiver: every result item that moves is checked against the oldest
  // prediction, then ready is redrawn for the next cycle. Values read here
  // are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.result_byte);
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one byte, with optional random idle cycles ahead of it, and
  // returns at the edge where the block takes it. Valid stays high on
  // return so that a back-to-back item follows without valid dropping.
  task automatic send_item(logic [7:0] data, logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= data;
    in_ch.message_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(data, start);
    items_sent++;
    if (start) message_count++;
  endtask

  // Stops offering bytes and waits until every predicted result has come
  // back, then lets the block settle. Always advances time.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after its last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Register setting for a test phase. The first three phases use fixed
  // settings: the published RFC 8439 test key, everything at its maximum,
  // and everything at zero. Later phases rewrite a random subset, so some
  // registers keep their value and a continued message sees the change only
  // from its next block on.
  task automatic apply_setting(int phase);
    logic [CFG_DATA_W-1:0] val;
    for (int k = int'(CFG_KEY0); k <= int'(CFG_START_CNT); k++) begin
      case (phase)
        0: begin
          case (k[CFG_IDX_W-1:0])
            CFG_KEY0:      val = 64'h0706050403020100;
            CFG_KEY1:      val = 64'h0f0e0d0c0b0a0908;
            CFG_KEY2:      val = 64'h1716151413121110;
            CFG_KEY3:      val = 64'h1f1e1d1c1b1a1918;
            CFG_NONCE_LO:  val = 64'h4a000000_09000000;
            CFG_NONCE_HI:  val = 64'h0;
            default:       val = 64'h1;
          endcase
          cfg_write(k[CFG_IDX_W-1:0], val);
        end
        1: cfg_write(k[CFG_IDX_W-1:0], '1);
        2: cfg_write(k[CFG_IDX_W-1:0], '0);
        default: begin
          val = {$urandom, $urandom};
          // Counters close to the top make the wrap to zero likely.
          if (k[CFG_IDX_W-1:0] == CFG_START_CNT && $urandom_range(3) == 0) begin
            val[31:0] = 32'hffff_ffff - $urandom_range(2);
          end
          if ($urandom_range(1) == 1) cfg_write(k[CFG_IDX_W-1:0], val);
        end
      endcase
    end
    // A write to the unused index must leave every setting alone.
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  function automatic int message_length();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(8, 1);
    if (r < 80) return $urandom_range(80, 9);
    return $urandom_range(200, 81);
  endfunction

  initial begin
    int   msg_left;
    logic start;
    bit   first;

    sb = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_KEY0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.message_start = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with both sides running flat out. The very first byte
    // carries no message start, so the block has to start a message on its
    // own. A flagged start in the middle of a block must reload the counter.
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'ha5, 1'b0);
    send_item(8'h5a, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);

    // Every register at its maximum, including the top bits of the 32-bit
    // registers that the block has to drop, and the start counter at the
    // last value before the wrap.
    drain_results();
    for (int k = int'(CFG_KEY0); k <= int'(CFG_START_CNT); k++) begin
      cfg_write(k[CFG_IDX_W-1:0], '1);
    end
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
    setting_count++;
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'haa, 1'b0);

    // Writes in the middle of a message: the current block keeps its
    // keystream, so these two bytes still use the old key and nonce.
    drain_results();
    cfg_write(CFG_KEY0, {$urandom, $urandom});
    cfg_write(CFG_NONCE_HI, {$urandom, $urandom});
    cfg_we <= 1'b0;
    send_item(8'h3c, 1'b0);
    send_item(8'hc3, 1'b0);

    // Random part: messages of random length and content, one register
    // setting per phase, and the idle pattern rotating through flat out,
    // a lazy sender, a stalling receiver, and both idling now and then.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      apply_setting(p);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 17;
          stall_pct = 17;
        end
      endcase
      msg_left = 0;
      first    = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // In the lazy-sender phases the sender also stops halfway and lets
        // the block empty completely before going on.
        if (p % 4 == 1 && i == PHASE_ITEMS / 2) drain_results();
        if (p == 1 && first) begin
          // Counter at its maximum and a message long enough to wrap it.
          msg_left = 150;
          start    = 1'b1;
        end else if (msg_left == 0) begin
          msg_left = message_length();
          // A phase may carry on with the message of the previous phase.
          start    = !(first && $urandom_range(1) == 1);
        end else begin
          start    = 1'b0;
        end
        first = 1'b0;
        send_item(8'($urandom_range(255)), start);
        msg_left--;
      end
    end

    drain_results();

    $display("summary: %0d bytes in %0d flagged messages, %0d keystream blocks, %0d settings",
             items_sent, message_count, sb.blocks_made, setting_count);
    $display("summary: %0d mismatches, %0d cycles", sb.errors, cycles);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
